>>> hw/rtl/hhq_pkg.sv
// Package for the heartbeat health qualifier.
// Holds the item structs, register indexes, operation codes and reset values.
// No dependencies.
package hhq_pkg;

  localparam int unsigned TIME_BITS = 48;
  localparam int unsigned CFG_IDX_BITS = 2;

  localparam logic [CFG_IDX_BITS-1:0] REG_ENABLED = 2'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_FRESH_TIMEOUT = 2'd1;
  localparam logic [CFG_IDX_BITS-1:0] REG_RECOVERY_HOLD = 2'd2;

  localparam logic OP_REPORT = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam longint unsigned FRESH_TIMEOUT_RESET = 64'd500000;
  localparam longint unsigned RECOVERY_HOLD_RESET = 64'd1000000;

  typedef struct packed {
    logic                 operation;
    logic                 healthy;
    logic [TIME_BITS-1:0] timestamp;
  } in_item_t;

  typedef struct packed {
    logic allowed;
    logic fresh;
  } out_item_t;

endpackage

>>> hw/rtl/heartbeat_health_qualifier_unit.sv
// Top level of the heartbeat health qualifier.
// Depends on hhq_pkg for item structs, register indexes and operation codes.
//
//   Port group  Direction  Handshake        Payload
//   in_         input      valid / ready    in_item_t
//   out_        output     valid / ready    out_item_t
//   cfg_        input      write enable     index, DURATION_BITS data
//
// An item is registered on acceptance and evaluated against the state in the next
// cycle; a query result is written to the output register when the item advances.
// One item is accepted every cycle unless a stalled query holds the input register
// while the output register is full and not taken. Reset is synchronous and clears
// the valid flags and qualifier state; a defined config write clears the state too.
module heartbeat_health_qualifier_unit
  import hhq_pkg::*;
#(
  parameter int unsigned DURATION_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  in_item_t                 in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output out_item_t                out_data,
  input  logic                     cfg_we,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index,
  input  logic [DURATION_BITS-1:0] cfg_data
);

  localparam logic [DURATION_BITS-1:0] FRESH_RST = DURATION_BITS'(FRESH_TIMEOUT_RESET);
  localparam logic [DURATION_BITS-1:0] HOLD_RST = DURATION_BITS'(RECOVERY_HOLD_RESET);

  logic                     enabled_r;
  logic [DURATION_BITS-1:0] fresh_timeout_r;
  logic [DURATION_BITS-1:0] recovery_hold_r;

  logic                 seen_r, seen_nxt;
  logic                 last_healthy_r, last_healthy_nxt;
  logic                 qualifying_r, qualifying_nxt;
  logic [TIME_BITS-1:0] last_time_r, last_time_nxt;
  logic [TIME_BITS-1:0] start_time_r, start_time_nxt;

  logic      item_valid_r;
  in_item_t  item_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic                 is_query;
  logic                 item_advance;
  logic                 cfg_hit;
  logic [TIME_BITS-1:0] t;
  logic [TIME_BITS-1:0] age;
  logic [TIME_BITS-1:0] held;
  logic                 before_last;
  logic                 before_start;
  logic                 fresh_now;
  logic                 allowed_now;
  logic                 broken;

  assign is_query = item_r.operation == OP_QUERY;
  assign item_advance = item_valid_r && (!is_query || !out_valid_r || out_ready);
  assign in_ready = !item_valid_r || item_advance;
  assign cfg_hit = cfg_we && (cfg_index == REG_ENABLED || cfg_index == REG_FRESH_TIMEOUT ||
                              cfg_index == REG_RECOVERY_HOLD);

  assign t = item_r.timestamp;
  assign age = t - last_time_r;
  assign held = t - start_time_r;
  assign before_last = t < last_time_r;
  assign before_start = t < start_time_r;

  assign fresh_now = enabled_r && seen_r && last_healthy_r && !before_last &&
                     (age < TIME_BITS'(fresh_timeout_r));
  assign allowed_now = fresh_now && qualifying_r && !before_start &&
                       (held >= TIME_BITS'(recovery_hold_r));
  assign broken = !seen_r || !last_healthy_r || (age >= TIME_BITS'(fresh_timeout_r));

  always_comb begin
    seen_nxt = seen_r;
    last_healthy_nxt = last_healthy_r;
    qualifying_nxt = qualifying_r;
    last_time_nxt = last_time_r;
    start_time_nxt = start_time_r;
    if (is_query) begin
      if (!fresh_now) begin
        qualifying_nxt = 1'b0;
      end
    end else if (!enabled_r) begin
      last_healthy_nxt = 1'b0;
      qualifying_nxt = 1'b0;
    end else if (seen_r && before_last) begin
      last_healthy_nxt = 1'b0;
      qualifying_nxt = 1'b0;
      last_time_nxt = t;
    end else begin
      seen_nxt = 1'b1;
      last_healthy_nxt = item_r.healthy;
      last_time_nxt = t;
      if (!item_r.healthy) begin
        qualifying_nxt = 1'b0;
      end else if (broken || !qualifying_r) begin
        qualifying_nxt = 1'b1;
        start_time_nxt = t;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r <= 1'b0;
      fresh_timeout_r <= FRESH_RST;
      recovery_hold_r <= HOLD_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENABLED:       enabled_r <= cfg_data[0];
        REG_FRESH_TIMEOUT: fresh_timeout_r <= cfg_data;
        REG_RECOVERY_HOLD: recovery_hold_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cfg_hit) begin
      seen_r <= 1'b0;
      last_healthy_r <= 1'b0;
      qualifying_r <= 1'b0;
      last_time_r <= '0;
      start_time_r <= '0;
    end else if (item_advance) begin
      seen_r <= seen_nxt;
      last_healthy_r <= last_healthy_nxt;
      qualifying_r <= qualifying_nxt;
      last_time_r <= last_time_nxt;
      start_time_r <= start_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_ready) begin
        item_valid_r <= in_valid;
      end
      if (item_advance && is_query) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_data;
    end
    if (item_advance && is_query) begin
      out_data_r.allowed <= allowed_now;
      out_data_r.fresh <= fresh_now;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

endmodule

>>> hw/rtl/hhq_checker.sv
// Port-level checker for the heartbeat health qualifier and its bind statement.
// Depends on hhq_pkg and on heartbeat_health_qualifier_unit.
module hhq_checker
  import hhq_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("Result valid after reset.");

  a_allowed_needs_fresh: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.allowed |-> out_data.fresh)
    else $error("Control allowed on a result that is not fresh.");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result item changed or dropped.");

endmodule

bind heartbeat_health_qualifier_unit hhq_checker u_hhq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
